// ===== src/idp_pkg.sv =====
// Shared types, constants and unit tables for the ISO 8601 duration parser.
// Used by idp_front, idp_back and the top level; depends on nothing.
`default_nettype none
package idp_pkg;

  localparam int FRAC_DIGITS = 16;
  localparam int SEC_DIGITS  = 7;    // fraction digits that stay whole 100 ns units
  localparam int FD_N        = (FRAC_DIGITS > SEC_DIGITS) ? FRAC_DIGITS : SEC_DIGITS;
  localparam int FD_AW       = $clog2(FD_N);
  localparam int MULT_W      = 49;   // widest unit multiplier (one year)
  localparam int SEC_W       = 25;   // widest unit in seconds (one year)
  localparam int NUM_W       = SEC_W + 4;
  localparam int FS_W        = 50;   // product of the leading fraction digits
  localparam int N_UNITS     = 7;
  localparam int HOUR_POS    = 4;
  localparam int MUL_CNT_W   = $clog2(MULT_W);
  localparam int QDEPTH      = 4;
  localparam int QAW         = $clog2(QDEPTH);

  // floor(x / 10) = (x * RECIP10) >> 35 for any 32-bit x
  localparam logic [31:0] RECIP10 = 32'hCCCCCCCD;

  localparam logic [1:0] PH_EXPECT_P = 2'd0;
  localparam logic [1:0] PH_START    = 2'd1;
  localparam logic [1:0] PH_VALUE    = 2'd2;
  localparam logic [1:0] PH_ERROR    = 2'd3;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_SYNTAX = 2'd1;
  localparam logic [1:0] ERR_RANGE  = 2'd2;

  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    CLS_DIGIT,
    CLS_POINT,
    CLS_T,
    CLS_P,
    CLS_OTHER
  } ch_class_t;

  typedef struct packed {
    ch_class_t            cls;
    logic [3:0]           digit;
    logic [N_UNITS-1:0]   unit_hit;
    logic                 last;
  } q_entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_FRAC,
    S_SUM,
    S_ACC,
    S_EMIT
  } back_state_t;

  function automatic logic [7:0] unit_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h59;  // Y
      3'd1:    c = 8'h4d;  // M, month
      3'd2:    c = 8'h57;  // W
      3'd3:    c = 8'h44;  // D
      3'd4:    c = 8'h48;  // H
      3'd5:    c = 8'h4d;  // M, minute
      3'd6:    c = 8'h53;  // S
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // 100 ns units per component
  function automatic logic [MULT_W-1:0] unit_mult(input logic [2:0] idx);
    logic [MULT_W-1:0] m;
    unique case (idx)
      3'd0:    m = MULT_W'(64'd315360000000000);
      3'd1:    m = MULT_W'(64'd26784000000000);
      3'd2:    m = MULT_W'(64'd6048000000000);
      3'd3:    m = MULT_W'(64'd864000000000);
      3'd4:    m = MULT_W'(64'd36000000000);
      3'd5:    m = MULT_W'(64'd600000000);
      3'd6:    m = MULT_W'(64'd10000000);
      default: m = '0;
    endcase
    return m;
  endfunction

  // seconds per component
  function automatic logic [SEC_W-1:0] unit_secs(input logic [2:0] idx);
    logic [SEC_W-1:0] s;
    unique case (idx)
      3'd0:    s = SEC_W'(32'd31536000);
      3'd1:    s = SEC_W'(32'd2678400);
      3'd2:    s = SEC_W'(32'd604800);
      3'd3:    s = SEC_W'(32'd86400);
      3'd4:    s = SEC_W'(32'd3600);
      3'd5:    s = SEC_W'(32'd60);
      3'd6:    s = SEC_W'(32'd1);
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// ===== src/idp_front.sv =====
// Front end: accepts characters, classifies them and queues them for the back end.
// Depends on idp_pkg.
`default_nettype none
module idp_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        ch,
  input  wire logic              last,
  output logic                   q_valid,
  output idp_pkg::q_entry_t      q_data,
  input  wire logic              q_pop
);
  import idp_pkg::*;

  q_entry_t       mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   cnt;
  q_entry_t       cls_entry;
  logic           push;

  always_comb begin
    cls_entry = '0;
    cls_entry.last  = last;
    cls_entry.digit = 4'(ch - CH_ZERO);
    if (ch >= CH_ZERO && ch <= CH_NINE) cls_entry.cls = CLS_DIGIT;
    else if (ch == CH_DOT || ch == CH_COMMA) cls_entry.cls = CLS_POINT;
    else if (ch == CH_T) cls_entry.cls = CLS_T;
    else if (ch == CH_P) cls_entry.cls = CLS_P;
    else cls_entry.cls = CLS_OTHER;
    for (int i = 0; i < N_UNITS; i++) begin
      cls_entry.unit_hit[i] = (ch == unit_char(3'(i)));
    end
  end

  assign in_ready = (cnt != (QAW+1)'(QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt != '0);
  assign q_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= cls_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (q_pop) rd_ptr <= rd_ptr + 1'b1;
      cnt <= cnt + (QAW+1)'(push) - (QAW+1)'(q_pop);
    end
  end

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt <= (QAW+1)'(QDEPTH))
    else $error("queue count out of range");
  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    push && !q_pop |=> cnt == $past(cnt) + 1'b1)
    else $error("queue count did not advance on push");
`endif

endmodule
`default_nettype wire

// ===== src/idp_back.sv =====
// Back end: parses queued characters, scales components by their units with a
// serial multiply and a digit-wise fraction pass, and holds the result register.
// Depends on idp_pkg.
`default_nettype none
module idp_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  input  wire idp_pkg::q_entry_t q_data,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   valid_res,
  output logic [1:0]             error_kind,
  output logic [63:0]            duration
);
  import idp_pkg::*;

  back_state_t st, st_next;

  logic [1:0]           phase;
  logic [2:0]           order_index;
  logic                 time_seen;
  logic [63:0]          int_acc;
  logic [3:0]           frac_dig [FD_N];
  logic [4:0]           frac_count;
  logic                 seen_digits;
  logic                 seen_point;
  logic [63:0]          total;
  logic [1:0]           err_code;
  logic                 last_pend;
  logic [MULT_W-1:0]    mreg;
  logic [MUL_CNT_W-1:0] mul_cnt;
  logic [63:0]          iacc;
  logic                 iovf;
  logic [SEC_W-1:0]     ksec;
  logic [FS_W-1:0]      kp;
  logic [FS_W-1:0]      fsum;
  logic [NUM_W-1:0]     rsum;
  logic [FD_AW-1:0]     fidx;
  logic [63:0]          sum;

  // decode of the head character
  logic              is_val;
  logic              des;
  logic              found;
  logic [2:0]        found_idx;
  logic              start_calc;
  logic [67:0]       int_next;
  logic              mul_done;
  logic              frac_done;
  logic              frac_nz;
  logic              load_out;
  logic [64:0]       mul_dbl;
  logic [64:0]       mul_add;
  logic [3:0]        cur_dig;
  logic [NUM_W-1:0]  dk;
  logic [31:0]       num;
  logic [63:0]       q_prod;
  logic [FS_W-1:0]   pk;
  logic [FS_W-1:0]   kp10;
  logic [63:0]       fpart;
  logic [64:0]       sum_w;
  logic [64:0]       tot_w;
  logic [1:0]        err_final;
  logic              ok_final;

  always_comb begin
    is_val = (phase == PH_START && q_data.cls != CLS_T) || (phase == PH_VALUE);
    des    = is_val && q_data.cls != CLS_DIGIT && q_data.cls != CLS_POINT;
    found     = 1'b0;
    found_idx = '0;
    for (int i = 0; i < N_UNITS; i++) begin
      if (!found && q_data.unit_hit[i] && 3'(i) >= order_index) begin
        found     = 1'b1;
        found_idx = 3'(i);
      end
    end
    frac_nz = 1'b0;
    for (int i = 0; i < FD_N; i++) begin
      frac_nz = frac_nz | (frac_dig[i] != 4'd0);
    end
    start_calc = des && !(seen_point && !seen_digits) && found;
    int_next   = ({4'b0, int_acc} << 3) + ({4'b0, int_acc} << 1) + 68'(q_data.digit);
    mul_done   = (mul_cnt == MUL_CNT_W'(MULT_W - 1));
    frac_done  = (fidx == '0);
    mul_dbl    = {iacc, 1'b0};
    mul_add    = {1'b0, mul_dbl[63:0]} + (mreg[MULT_W-1] ? {1'b0, int_acc} : 65'd0);
    // trailing digits: running floor of (digit * seconds + carry) / 10
    cur_dig    = frac_dig[fidx];
    dk         = NUM_W'(cur_dig) * NUM_W'(ksec);
    num        = 32'(dk) + 32'(rsum);
    q_prod     = 64'(num) * 64'(RECIP10);
    // leading digits: exact digit * seconds * 10^k
    pk         = FS_W'(cur_dig) * kp;
    kp10       = (kp << 3) + (kp << 1);
    fpart      = 64'(fsum) + 64'(rsum);
    sum_w      = {1'b0, iacc} + {1'b0, fpart};
    tot_w      = {1'b0, total} + {1'b0, sum};
    err_final  = (phase == PH_VALUE && err_code == ERR_NONE) ? ERR_SYNTAX : err_code;
    ok_final   = (phase == PH_START && err_code == ERR_NONE);
  end

  // next state
  always_comb begin
    st_next = st;
    unique case (st)
      S_IDLE: begin
        if (q_valid) begin
          if (start_calc) st_next = S_MUL;
          else if (q_data.last) st_next = S_EMIT;
        end
      end
      S_MUL:  if (mul_done) st_next = S_FRAC;
      S_FRAC: if (frac_done) st_next = S_SUM;
      S_SUM: begin
        if (iovf || sum_w[64] || (sum_w[63:0] == '0 && frac_nz))
          st_next = last_pend ? S_EMIT : S_IDLE;
        else st_next = S_ACC;
      end
      S_ACC:  st_next = last_pend ? S_EMIT : S_IDLE;
      S_EMIT: if (load_out) st_next = S_IDLE;
      default: st_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop    = 1'b0;
    load_out = 1'b0;
    unique case (st)
      S_IDLE:  q_pop = q_valid;
      S_EMIT:  load_out = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) st <= S_IDLE;
    else st <= st_next;
  end

  // parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_EXPECT_P;
      order_index <= '0;
      time_seen   <= 1'b0;
      int_acc     <= '0;
      frac_dig    <= '{default: '0};
      frac_count  <= '0;
      seen_digits <= 1'b0;
      seen_point  <= 1'b0;
      total       <= '0;
      err_code    <= ERR_NONE;
      last_pend   <= 1'b0;
    end else begin
      unique case (st)
        S_IDLE: begin
          if (q_valid) begin
            last_pend <= q_data.last;
            if (phase == PH_EXPECT_P) begin
              if (q_data.cls == CLS_P) phase <= PH_START;
              else begin
                phase    <= PH_ERROR;
                err_code <= ERR_SYNTAX;
              end
            end else if (phase == PH_START && q_data.cls == CLS_T) begin
              if (time_seen) begin
                phase    <= PH_ERROR;
                err_code <= ERR_SYNTAX;
              end else begin
                time_seen   <= 1'b1;
                order_index <= 3'(HOUR_POS);
                phase       <= PH_VALUE;
              end
            end else if (is_val) begin
              if (q_data.cls == CLS_POINT) begin
                if (!seen_digits || seen_point) begin
                  phase    <= PH_ERROR;
                  err_code <= ERR_SYNTAX;
                end else begin
                  seen_point  <= 1'b1;
                  seen_digits <= 1'b0;
                  phase       <= PH_VALUE;
                end
              end else if (q_data.cls == CLS_DIGIT) begin
                seen_digits <= 1'b1;
                phase       <= PH_VALUE;
                if (seen_point) begin
                  if (frac_count < 5'(FRAC_DIGITS)) begin
                    frac_dig[FD_AW'(frac_count)] <= q_data.digit;
                    frac_count <= frac_count + 1'b1;
                  end
                end else if (int_next[67:64] != '0) begin
                  phase    <= PH_ERROR;
                  err_code <= ERR_RANGE;
                end else begin
                  int_acc <= int_next[63:0];
                end
              end else if (start_calc) begin
                order_index <= found_idx;
              end else begin
                phase    <= PH_ERROR;
                err_code <= ERR_SYNTAX;
              end
            end
          end
        end
        S_SUM: begin
          if (iovf || sum_w[64] || (sum_w[63:0] == '0 && frac_nz)) begin
            phase    <= PH_ERROR;
            err_code <= ERR_RANGE;
          end
        end
        S_ACC: begin
          if (tot_w[64]) begin
            phase    <= PH_ERROR;
            err_code <= ERR_RANGE;
          end else begin
            total       <= tot_w[63:0];
            phase       <= PH_START;
            int_acc     <= '0;
            frac_dig    <= '{default: '0};
            frac_count  <= '0;
            seen_digits <= 1'b0;
            seen_point  <= 1'b0;
          end
        end
        S_EMIT: begin
          if (load_out) begin
            phase       <= PH_EXPECT_P;
            order_index <= '0;
            time_seen   <= 1'b0;
            int_acc     <= '0;
            frac_dig    <= '{default: '0};
            frac_count  <= '0;
            seen_digits <= 1'b0;
            seen_point  <= 1'b0;
            total       <= '0;
            err_code    <= ERR_NONE;
          end
        end
        default: ;
      endcase
    end
  end

  // serial multiply of the integer part (MSB first over the unit), then one
  // step per fraction digit from the last digit back to the first
  always_ff @(posedge clk) begin
    unique case (st)
      S_IDLE: begin
        mreg    <= unit_mult(found_idx);
        ksec    <= unit_secs(found_idx);
        kp      <= FS_W'(unit_secs(found_idx));
        mul_cnt <= '0;
        iacc    <= '0;
        iovf    <= 1'b0;
        fsum    <= '0;
        rsum    <= '0;
        fidx    <= FD_AW'(FD_N - 1);
      end
      S_MUL: begin
        mreg    <= mreg << 1;
        mul_cnt <= mul_cnt + 1'b1;
        iacc    <= mul_add[63:0];
        iovf    <= iovf | mul_dbl[64] | mul_add[64];
      end
      S_FRAC: begin
        fidx <= fidx - 1'b1;
        if (fidx >= FD_AW'(SEC_DIGITS)) begin
          rsum <= q_prod[63:35];
        end else begin
          fsum <= fsum + pk;
          kp   <= kp10;
        end
      end
      S_SUM: sum <= sum_w[63:0];
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (load_out) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      valid_res  <= ok_final;
      error_kind <= ok_final ? ERR_NONE : err_final;
      duration   <= ok_final ? total : 64'd0;
    end
  end

`ifndef SYNTHESIS
  a_pop_idle: assert property (@(posedge clk) disable iff (rst) q_pop |-> st == S_IDLE)
    else $error("character taken outside idle");
  a_frac_start: assert property (@(posedge clk) disable iff (rst)
    st == S_MUL && mul_done |=> st == S_FRAC && fidx == FD_AW'(FD_N - 1))
    else $error("fraction pass did not start at the last digit");
  a_err_phase: assert property (@(posedge clk) disable iff (rst)
    err_code != ERR_NONE |-> phase == PH_ERROR)
    else $error("error recorded without error phase");
  a_fresh_total: assert property (@(posedge clk) disable iff (rst)
    phase == PH_EXPECT_P |-> total == '0)
    else $error("total not cleared at string start");
`endif

endmodule
`default_nettype wire

// ===== src/iso8601_duration_parser.sv =====
// ISO 8601 duration parser, top level: character front end and parsing back end.
// Depends on idp_pkg, idp_front and idp_back.
//
// Input channel (in_valid/in_ready): one ASCII character per word in ch, with
// last set on the final character of the string. Output channel
// (out_valid/out_ready): one word per string, sent after its last character:
// valid_res, error_kind (0 none, 1 syntax, 2 range) and duration in 100 ns.
// Characters pass a four-word queue, so the sender keeps going while the
// back end works on a component.
// A character that is not a unit designator is handled by the back end in its
// idle state as it is popped. A designator runs through the pop, a serial
// multiply of the integer part over the 49-bit unit constant, one step per
// fraction digit (FRAC_DIGITS of them), then a sum step and, unless that finds
// a range error, an accumulate step. After the last character and any pending
// designator work, the emit state loads the result register and sets out_valid.
// Reset (rst, synchronous) empties the queue, drops any pending result and
// readies the parser for a new string. When the receiver stalls, the result
// register holds the word; the back end waits with the next result, and the
// queue then fills and drops in_ready.
`default_nettype none
module iso8601_duration_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  ch,
  input  wire logic        last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             valid_res,
  output logic [1:0]       error_kind,
  output logic [63:0]      duration
);
  import idp_pkg::*;

  logic     q_valid;
  q_entry_t q_data;
  logic     q_pop;

  idp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .ch       (ch),
    .last     (last),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop)
  );

  idp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .valid_res  (valid_res),
    .error_kind (error_kind),
    .duration   (duration)
  );

endmodule
`default_nettype wire
